// File: sv/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list engine package
// Command and result word types, command and status codes, and the
// control word that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_POP    = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] value;
	} cmd_word_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  count;
		logic        head_valid;
		logic [15:0] head_value;
		logic [4:0]  removed;
	} rsp_word_t;

	// Controller to datapath: capture a command, run the compare step,
	// commit the new list contents and the result.
	typedef struct packed {
		logic load;
		logic compare;
		logic apply;
	} ctrl_t;

endpackage

`default_nettype wire

// File: sv/sorted_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list engine
// A bounded list of unsigned values kept in ascending order, driven by
// insert, remove-equal, pop and clear commands, one result word each.
// ----------------------------------------------------------------------------
//
//   Channel   Ports              Handshake
//   -------   ----------------   ------------------------------------------
//   command   cmd, start, busy   word taken on a clock edge with start high
//                                and busy low
//   result    rsp, done          word valid for the one cycle done is high
//
// Every command goes through two steps: a compare step in which each slot
// compares against the command value in parallel, and a commit step in
// which the slots load their new contents and the result word is
// registered. The result appears on the cycle after the commit step.
// Busy is high only during the compare step, so a new command word can
// be taken during the commit step, while the last command finishes.
// The result side has no back pressure; the receiver must take each word.
// Reset clears the fill count and the controller; slot contents are not
// reset and are never read before they are written.
//
module sorted_list_engine import sle_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire cmd_word_t cmd,
	output logic           done,
	output rsp_word_t      rsp
);

	// Control word from the sequencer to the datapath.
	ctrl_t ctrl;

	// The controller steps each command through compare and commit.
	sle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// The datapath holds the slots, the fill count and the result word.
	sle_datapath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: sv/sle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list engine controller
// Sequences each command through a compare step and a commit step.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	output ctrl_t      ctrl
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CMP   = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A new word may enter during the commit step.
	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_CMP;
			S_CMP:   state_d = S_APPLY;
			S_APPLY: state_d = accept ? S_CMP : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctrl.load    = accept;
	assign ctrl.compare = (state_q == S_CMP);
	assign ctrl.apply   = (state_q == S_APPLY);

	a_load_then_compare: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> ctrl.compare)
		else $error("accepted word not followed by compare step");

	a_compare_then_apply: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.compare |=> ctrl.apply)
		else $error("compare step not followed by commit step");

endmodule

`default_nettype wire

// File: sv/sle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list engine datapath
// Slot registers with per-slot compare, thermometer position encoders,
// a log shifter for run removal, and the result register.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ctrl_t     ctrl,
	input  wire cmd_word_t cmd,
	output logic           done,
	output rsp_word_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [VALUE_BITS-1:0] slot_q [CAPACITY];
	logic [VALUE_BITS-1:0] slot_d [CAPACITY];
	logic [VALUE_BITS-1:0] sh     [CW+1][CAPACITY];
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         fill_d;
	mode_t                 mode_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS+15:0] val_ext;

	logic [CAPACITY-1:0]   lt_mask;
	logic [CAPACITY-1:0]   le_mask;
	logic [CW-1:0]         first_enc;
	logic [CW-1:0]         last_enc;
	logic [CW-1:0]         first_q;
	logic [CW-1:0]         last_q;
	logic [CW-1:0]         run_len;

	status_t               status_d;
	logic [CW-1:0]         removed_d;
	logic                  pop_ok;
	logic [VALUE_BITS-1:0] head_sel;
	logic [VALUE_BITS+15:0] head_ext;
	logic [CW+4:0]         count_ext;
	logic [CW+4:0]         removed_ext;
	logic                  done_q;
	rsp_word_t             rsp_q;

	assign val_ext = {{VALUE_BITS{1'b0}}, cmd.value};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mode_q <= cmd.mode;
			val_q  <= val_ext[VALUE_BITS-1:0];
		end
	end

	// Compare step. Held entries are ascending, so both masks are
	// thermometer codes and their lengths come from a one-hot encode.
	always_comb begin
		lt_mask   = '0;
		le_mask   = '0;
		first_enc = '0;
		last_enc  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			lt_mask[i] = (CW'(i) < fill_q) && (slot_q[i] < val_q);
			le_mask[i] = (CW'(i) < fill_q) && (slot_q[i] <= val_q);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (lt_mask[i] && (i == CAPACITY - 1 || !lt_mask[(i + 1) % CAPACITY]))
				first_enc = first_enc | CW'(i + 1);
			if (le_mask[i] && (i == CAPACITY - 1 || !le_mask[(i + 1) % CAPACITY]))
				last_enc = last_enc | CW'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			first_q <= first_enc;
			last_q  <= last_enc;
		end
	end

	assign run_len = last_q - first_q;

	// Shift everything left by the length of the equal run.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			sh[0][i] = slot_q[i];
		end
		for (int b = 0; b < CW; b++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (run_len[b] && (i + (1 << b) < CAPACITY))
					sh[b+1][i] = sh[b][(i + (1 << b)) % CAPACITY];
				else
					sh[b+1][i] = sh[b][i];
			end
		end
	end

	// Commit step.
	always_comb begin
		fill_d    = fill_q;
		status_d  = ST_OK;
		removed_d = '0;
		pop_ok    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_d[i] = slot_q[i];
		end
		unique case (mode_q)
			MODE_INSERT: begin
				if (fill_q == CW'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					fill_d = fill_q + CW'(1);
					for (int i = 0; i < CAPACITY; i++) begin
						if (CW'(i) == first_q)
							slot_d[i] = val_q;
						else if (CW'(i) > first_q)
							slot_d[i] = slot_q[(i + CAPACITY - 1) % CAPACITY];
					end
				end
			end
			MODE_REMOVE: begin
				fill_d    = fill_q - run_len;
				removed_d = run_len;
				for (int i = 0; i < CAPACITY; i++) begin
					if (CW'(i) >= first_q)
						slot_d[i] = sh[CW][i];
				end
			end
			MODE_POP: begin
				if (fill_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pop_ok    = 1'b1;
					fill_d    = fill_q - CW'(1);
					removed_d = CW'(1);
					for (int i = 0; i < CAPACITY - 1; i++) begin
						slot_d[i] = slot_q[i+1];
					end
				end
			end
			MODE_CLEAR: begin
				fill_d    = '0;
				removed_d = fill_q;
			end
		endcase
	end

	always_comb begin
		if (pop_ok)
			head_sel = slot_q[0];
		else if (fill_d != '0)
			head_sel = slot_d[0];
		else
			head_sel = '0;
	end

	assign head_ext    = {16'b0, head_sel};
	assign count_ext   = {5'b0, fill_d};
	assign removed_ext = {5'b0, removed_d};

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_q[i] <= slot_d[i];
			end
			rsp_q.status     <= status_d;
			rsp_q.count      <= count_ext[4:0];
			rsp_q.head_valid <= (fill_d != '0);
			rsp_q.head_value <= head_ext[15:0];
			rsp_q.removed    <= removed_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.apply;
			if (ctrl.apply) fill_q <= fill_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count exceeds capacity");

	a_run_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.apply |-> (first_q <= last_q) && (last_q <= fill_q))
		else $error("position encoders out of order");

	a_full_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.apply && status_d == ST_FULL |=> fill_q == CW'(CAPACITY))
		else $error("dropped insert changed the fill count");

endmodule

`default_nettype wire

// File: tb/tb_sorted_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Sends insert, remove-equal, pop and clear command words, keeps its own
// sorted copy of the list to predict each result word, and compares every
// result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine;
	import sle_pkg::*;

	// Cycles without any command or result word taken before the run is
	// declared hung.
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_WORDS = 1075;

	// Holds the expected list contents and the result words still owed by
	// the block. Each accepted command word updates the list at once and
	// queues the word the block must return for it.
	class sorted_list_tracker;
		localparam int DEPTH = 16;

		logic [15:0] held [DEPTH];
		int          fill = 0;
		rsp_word_t   awaited_rsp [$];
		int          errors = 0;
		int          checked = 0;
		int          mode_seen [4] = '{0, 0, 0, 0};
		int          full_drops = 0;
		int          empty_pops = 0;
		int          matched_removes = 0;
		int          peak_fill = 0;

		function void apply_command(cmd_word_t c);
			rsp_word_t   r;
			int          i;
			int          pos;
			int          w;
			int          gone;
			logic [15:0] popped;
			logic        took;

			r = '0;
			r.status = ST_OK;
			gone = 0;
			popped = '0;
			took = 1'b0;
			mode_seen[int'(c.mode)]++;
			case (c.mode)
				MODE_INSERT: begin
					if (fill >= DEPTH) begin
						r.status = ST_FULL;
						full_drops++;
					end else begin
						// New entry goes in front of the first entry that is
						// greater than or equal to it.
						pos = 0;
						while (pos < fill && c.value > held[pos])
							pos++;
						for (i = fill; i > pos; i--)
							held[i] = held[i - 1];
						held[pos] = c.value;
						fill++;
					end
				end
				MODE_REMOVE: begin
					w = 0;
					for (i = 0; i < fill; i++) begin
						if (held[i] == c.value)
							gone++;
						else begin
							held[w] = held[i];
							w++;
						end
					end
					fill = w;
					if (gone != 0)
						matched_removes++;
				end
				MODE_POP: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
						empty_pops++;
					end else begin
						popped = held[0];
						took = 1'b1;
						for (i = 1; i < fill; i++)
							held[i - 1] = held[i];
						fill--;
						gone = 1;
					end
				end
				default: begin
					gone = fill;
					fill = 0;
				end
			endcase
			if (fill > peak_fill)
				peak_fill = fill;
			r.count = 5'(fill);
			r.head_valid = (fill != 0);
			if (took)
				r.head_value = popped;
			else if (fill != 0)
				r.head_value = held[0];
			else
				r.head_value = '0;
			r.removed = 5'(gone);
			awaited_rsp.push_back(r);
		endfunction

		function void check_result(rsp_word_t got);
			rsp_word_t want;

			if (awaited_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result word with none outstanding: status=%0d count=%0d",
						$time, got.status, got.count);
				return;
			end
			want = awaited_rsp.pop_front();
			checked++;
			if (got.status !== want.status || got.count !== want.count ||
				got.head_valid !== want.head_valid ||
				got.head_value !== want.head_value ||
				got.removed !== want.removed) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected status=%0d count=%0d head_valid=%0d head=%h removed=%0d",
						want.status, want.count, want.head_valid, want.head_value,
						want.removed);
					$display("  actual   status=%0d count=%0d head_valid=%0d head=%h removed=%0d",
						got.status, got.count, got.head_valid, got.head_value,
						got.removed);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	cmd_word_t cmd;
	rsp_word_t rsp;

	int stall_cycles = 0;

	sorted_list_tracker tracker = new;

	sorted_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result monitor and watchdog. Everything here samples the values that
	// were present during the cycle that this edge ends, so it agrees with
	// what the block itself saw. The receiver has no way to stall the block,
	// so every strobed word is taken.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(rsp);
		if (!arst_n || done === 1'b1 || (start && busy === 1'b0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_sorted_list_engine: done, errors");
			$finish;
		end
	end

	// Presents one command word, optionally after some idle cycles with
	// start low, and holds it until an edge takes it. The word is taken on
	// the edge where busy was low, and the prediction is made right then.
	task automatic send_command(input mode_t m, input logic [15:0] v, input int gap);
		cmd_word_t w;

		w.mode = m;
		w.value = v;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.apply_command(w);
	endtask

	// Holds the command side quiet until every owed result word is back.
	// At least one edge always passes, so start never sees two assignments
	// in the same step.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (tracker.awaited_rsp.size() != 0);
	endtask

	initial begin
		int          k;
		int          roll;
		int          ins_pct;
		int          gap;
		mode_t       m;
		logic [15:0] v;

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. Commands on an empty list first: pop reports empty,
		// remove finds nothing, clear removes nothing.
		send_command(MODE_POP, 16'h0000, 0);
		send_command(MODE_REMOVE, 16'h0000, 0);
		send_command(MODE_CLEAR, 16'hFFFF, 0);
		// Extreme values and an equal pair, which must sit side by side.
		send_command(MODE_INSERT, 16'hFFFF, 0);
		send_command(MODE_INSERT, 16'h0000, 0);
		send_command(MODE_INSERT, 16'h8000, 0);
		send_command(MODE_INSERT, 16'h8000, 0);
		// A remove that matches nothing, then one that takes both equal
		// entries and closes the gap.
		send_command(MODE_REMOVE, 16'h1234, 0);
		send_command(MODE_REMOVE, 16'h8000, 0);
		// Pop returns the smallest entry, leaving only the largest.
		send_command(MODE_POP, 16'h5555, 0);
		// Fill the list to capacity, push one more that must be dropped,
		// then clear a full list.
		for (k = 0; k < 15; k++)
			send_command(MODE_INSERT, 16'(k * 4369), 0);
		send_command(MODE_INSERT, 16'h7FFF, 0);
		send_command(MODE_CLEAR, 16'h0000, 0);
		drain_results();

		// Random part. The mix swings between insert-heavy and pop-heavy
		// stretches so the list keeps going from empty to full and back.
		// Half the values come from a tiny pool so that duplicates and
		// matching removes are common.
		for (k = 0; k < RANDOM_WORDS; k++) begin
			ins_pct = ((k / 150) % 2 == 0) ? 70 : 35;
			roll = $urandom_range(99);
			if (roll < ins_pct)
				m = MODE_INSERT;
			else if (roll < ins_pct + 12)
				m = MODE_REMOVE;
			else if (roll < 97)
				m = MODE_POP;
			else
				m = MODE_CLEAR;
			roll = $urandom_range(99);
			if (roll < 50)
				v = 16'($urandom_range(9));
			else if (roll < 60)
				v = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
			else
				v = 16'($urandom);
			// Command words 400 through 649 go back to back with no gaps.
			if (k >= 400 && k < 650)
				gap = 0;
			else
				gap = ($urandom_range(99) < 21) ? $urandom_range(1, 6) : 0;
			send_command(m, v, gap);
			if ($urandom_range(199) == 0)
				drain_results();
		end
		start <= 1'b0;

		while (tracker.awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d commands: %0d insert, %0d remove, %0d pop, %0d clear; %0d results",
			tracker.mode_seen[0] + tracker.mode_seen[1] + tracker.mode_seen[2] +
			tracker.mode_seen[3], tracker.mode_seen[0], tracker.mode_seen[1],
			tracker.mode_seen[2], tracker.mode_seen[3], tracker.checked);
		$display("Full-list drops %0d, empty pops %0d, matching removes %0d, peak fill %0d",
			tracker.full_drops, tracker.empty_pops, tracker.matched_removes,
			tracker.peak_fill);
		if (tracker.errors == 0 && tracker.awaited_rsp.size() == 0)
			$display("tb_sorted_list_engine: done, clean");
		else
			$display("tb_sorted_list_engine: done, errors");
		$finish;
	end

endmodule

// File: sorted_list_engine.f
sv/sle_pkg.sv
sv/sle_ctrl.sv
sv/sle_datapath.sv
sv/sorted_list_engine.sv
tb/tb_sorted_list_engine.sv
